@@ rtl/car_pkg.sv @@
// ----------------------------------------------------------------------------
// car_pkg: shared types and constants of the common average reference
// Field widths, register indexes, controller states and the cell control word.
// ----------------------------------------------------------------------------
package car_pkg;

	localparam int CHANNELS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SAMPLE_W  = 16;
	localparam int CHAN_W    = 5;
	localparam int VALUE_W   = 17;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int MASK_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_USE_MEDIAN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MASK = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_REF   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		S_LOAD,
		S_PREP,
		S_MED,
		S_DIV,
		S_EMIT
	} state_t;

	// per-cycle control shared by all cells of the chain
	typedef struct packed {
		logic load;       // write the incoming sample at the write index
		logic ins;        // insert the incoming sample into the sorted chain
		logic shift_raw;  // move raw samples one cell toward cell 0
		logic shift_srt;  // move sorted samples one cell toward cell 0
	} cell_ctl_t;

endpackage

@@ rtl/car_in_if.sv @@
// ----------------------------------------------------------------------------
// car_in_if: sample channel
// One channel sample per beat, last_in_row closes the row.
// ----------------------------------------------------------------------------
interface car_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [car_pkg::SAMPLE_W-1:0] sample;
	logic                                last_in_row;

	modport source (output valid, output sample, output last_in_row, input ready);
	modport sink (input valid, input sample, input last_in_row, output ready);
	modport monitor (input valid, input sample, input last_in_row, input ready);
endinterface

@@ rtl/car_out_if.sv @@
// ----------------------------------------------------------------------------
// car_out_if: result channel
// One referenced channel sample per beat.
// ----------------------------------------------------------------------------
interface car_out_if;
	logic                                valid;
	logic                                ready;
	logic        [car_pkg::CHAN_W-1:0]   channel;
	logic signed [car_pkg::VALUE_W-1:0]  value;
	logic                                last;
	logic        [car_pkg::STATUS_W-1:0] status;

	modport source (output valid, output channel, output value, output last,
		output status, input ready);
	modport sink (input valid, input channel, input value, input last,
		input status, output ready);
	modport monitor (input valid, input channel, input value, input last,
		input status, input ready);
endinterface

@@ rtl/car_cell.sv @@
// ----------------------------------------------------------------------------
// car_cell: one cell of the sample chain
// Holds one raw sample in channel order and one sample of the sorted chain.
// ----------------------------------------------------------------------------
module car_cell #(
	parameter int IDX = 0,
	parameter int SB  = 16,
	parameter int CW  = 6
) (
	input  logic                  clk,
	input  car_pkg::cell_ctl_t    ctl,
	input  logic [CW-1:0]         wr_idx,
	input  logic signed [SB-1:0]  din,
	input  logic [CW-1:0]         n_incl,
	input  logic signed [SB-1:0]  prev_srt,
	input  logic                  prev_lt,
	input  logic signed [SB-1:0]  next_raw,
	input  logic signed [SB-1:0]  next_srt,
	output logic signed [SB-1:0]  raw,
	output logic signed [SB-1:0]  srt,
	output logic                  lt
);

	logic signed [SB-1:0] raw_q;
	logic signed [SB-1:0] srt_q;
	logic                 occ;

	// an empty slot acts as plus infinity
	assign occ = CW'(IDX) < n_incl;
	assign lt  = !occ || (din < srt_q);

	always_ff @(posedge clk) begin
		if (ctl.load && wr_idx == CW'(IDX)) begin
			raw_q <= din;
		end else if (ctl.shift_raw) begin
			raw_q <= next_raw;
		end
		if (ctl.ins) begin
			if (prev_lt) begin
				srt_q <= prev_srt;
			end else if (lt) begin
				srt_q <= din;
			end
		end else if (ctl.shift_srt) begin
			srt_q <= next_srt;
		end
	end

	assign raw = raw_q;
	assign srt = srt_q;

endmodule

@@ rtl/car_div.sv @@
// ----------------------------------------------------------------------------
// car_div: restoring unsigned divider
// One quotient bit per cycle, done pulses when the quotient is complete.
// ----------------------------------------------------------------------------
module car_div #(
	parameter int NW = 22,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int KW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + KW'(1);
				if (cnt_q == KW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/common_average_reference.sv @@
// ----------------------------------------------------------------------------
// common_average_reference: per-row common average / median reference
// Stores a row of channel samples in a chain of cells, forms the reference
// from the included channels and streams every channel minus the reference.
// ----------------------------------------------------------------------------
//
//  port      dir   beat payload                       notes
//  samples   sink  sample, last_in_row                one channel per beat
//  results   src   channel, value, last, status       one channel per beat
//  cfg_*     in    cfg_idx, cfg_data on cfg_we        use_median, exclude_mask
//
// A row of N samples loads at one beat per cycle. Closing the row passes
// through a setup state, then (n-1)/2 sorted-chain shifts and a step that
// takes the median, or through the serial divider for the mean, then one
// result beat per stored channel, one per cycle unless results stalls.
// samples.ready is low from the cycle after the closing beat until the
// last result beat is loaded into the output register. Reset clears
// control only; no clearing pass. A stalled result holds.
//
module common_average_reference #(
	parameter int CHANNELS    = car_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	car_in_if.sink                        samples,
	car_out_if.source                     results,
	input  logic                          cfg_we,
	input  logic [car_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [car_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int CW = $clog2(CHANNELS + 1);
	// sum of up to CHANNELS signed samples, plus headroom for the floor bias
	localparam int SW = SB + $clog2(CHANNELS) + 1;

	// configuration registers
	logic                         use_median_q;
	logic [car_pkg::MASK_W-1:0]   excl_mask_q;

	// row control
	car_pkg::state_t              st_q, st_d;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                n_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                emit_q;
	logic                         ovf_q;
	logic signed [SW-1:0]         sum_q;
	logic signed [SB:0]           ref_q;
	logic [car_pkg::STATUS_W-1:0] status_q;
	logic                         neg_q;

	// output register
	logic                         ov_q;
	logic [car_pkg::CHAN_W-1:0]   ochan_q;
	logic signed [car_pkg::VALUE_W-1:0] oval_q;
	logic                         olast_q;
	logic [car_pkg::STATUS_W-1:0] ostat_q;

	// datapath
	logic                         acc;
	logic                         room;
	logic                         incl;
	logic [6:0]                   fill_ext;
	logic [31:0]                  samp32;
	logic signed [SB-1:0]         din;
	logic                         out_free;
	logic                         emit_go;
	logic                         emit_end;
	car_pkg::cell_ctl_t           ctl;

	logic signed [SB-1:0]         raw_w [CHANNELS];
	logic signed [SB-1:0]         srt_w [CHANNELS];
	logic                         lt_w  [CHANNELS];

	logic                         div_start;
	logic                         div_done;
	logic [SW-1:0]                div_num;
	logic [SW-1:0]                div_q;
	logic signed [SB:0]           med_sum;
	logic signed [SB:0]           div_ref;
	logic signed [33:0]           diff;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_median_q <= 1'b0;
			excl_mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				car_pkg::REG_USE_MEDIAN:   use_median_q <= cfg_data[0];
				car_pkg::REG_EXCLUDE_MASK: excl_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input side ----------------
	assign samples.ready = (st_q == car_pkg::S_LOAD);
	assign acc           = samples.valid && samples.ready;
	assign room          = fill_q < CW'(CHANNELS);
	// channels at index 32 and above have no mask bit and always count
	assign fill_ext      = 7'(fill_q);
	assign incl          = !((fill_ext < 7'd32) && excl_mask_q[fill_ext[4:0]]);
	assign samp32        = {16'b0, samples.sample};
	assign din           = samp32[SB-1:0];

	// ---------------- output side ----------------
	assign out_free = !ov_q || results.ready;
	assign emit_go  = (st_q == car_pkg::S_EMIT) && out_free;
	assign emit_end = emit_go && (emit_q == fill_q - CW'(1));

	// ---------------- next state ----------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			car_pkg::S_LOAD: begin
				if (acc && samples.last_in_row) st_d = car_pkg::S_PREP;
			end
			car_pkg::S_PREP: begin
				if (n_q == '0)        st_d = car_pkg::S_EMIT;
				else if (use_median_q) st_d = car_pkg::S_MED;
				else                   st_d = car_pkg::S_DIV;
			end
			car_pkg::S_MED: begin
				if (cnt_q == '0) st_d = car_pkg::S_EMIT;
			end
			car_pkg::S_DIV: begin
				if (div_done) st_d = car_pkg::S_EMIT;
			end
			car_pkg::S_EMIT: begin
				if (emit_end) st_d = car_pkg::S_LOAD;
			end
			default: st_d = car_pkg::S_LOAD;
		endcase
	end

	// ---------------- controls ----------------
	always_comb begin
		ctl.load      = acc && room;
		ctl.ins       = acc && room && incl;
		ctl.shift_raw = emit_go;
		ctl.shift_srt = (st_q == car_pkg::S_MED) && (cnt_q != '0);
		div_start     = (st_q == car_pkg::S_PREP) && (n_q != '0) && !use_median_q;
	end

	// floor(sum/n) for negative sums: -ceil(|sum|/n) = -((|sum|+n-1)/n)
	assign div_num = sum_q[SW-1] ? SW'(-sum_q) + SW'(n_q) - SW'(1) : SW'(sum_q);
	assign div_ref = neg_q ? -(SB+1)'(div_q) : (SB+1)'(div_q);
	assign med_sum = (SB+1)'(srt_w[0]) + (SB+1)'(srt_w[1]);

	// ---------------- row registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= car_pkg::S_LOAD;
			fill_q <= '0;
			n_q    <= '0;
			cnt_q  <= '0;
			emit_q <= '0;
			ovf_q  <= 1'b0;
			sum_q  <= '0;
		end else begin
			st_q <= st_d;
			if (acc) begin
				if (room) begin
					fill_q <= fill_q + CW'(1);
					if (incl) begin
						n_q   <= n_q + CW'(1);
						sum_q <= sum_q + SW'(din);
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (st_q == car_pkg::S_PREP) begin
				// shift so the lower middle element lands in cell 0
				cnt_q <= (n_q - CW'(1)) >> 1;
			end else if (ctl.shift_srt) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (emit_end) begin
				fill_q <= '0;
				n_q    <= '0;
				emit_q <= '0;
				ovf_q  <= 1'b0;
				sum_q  <= '0;
			end else if (emit_go) begin
				emit_q <= emit_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == car_pkg::S_PREP) begin
			neg_q    <= sum_q[SW-1];
			status_q <= ovf_q ? car_pkg::ST_OVERFLOW :
				(n_q == '0 ? car_pkg::ST_NO_REF : car_pkg::ST_OK);
			ref_q    <= '0;
		end else if (st_q == car_pkg::S_MED && cnt_q == '0) begin
			ref_q <= n_q[0] ? (SB+1)'(srt_w[0]) : (med_sum >>> 1);
		end else if (st_q == car_pkg::S_DIV && div_done) begin
			ref_q <= div_ref;
		end
	end

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		logic signed [SB-1:0] p_srt, n_raw, n_srt;
		logic                 p_lt;
		if (i == 0) begin : g_head
			assign p_srt = srt_w[i];
			assign p_lt  = 1'b0;
		end else begin : g_body
			assign p_srt = srt_w[i-1];
			assign p_lt  = lt_w[i-1];
		end
		if (i == CHANNELS - 1) begin : g_tail
			assign n_raw = raw_w[i];
			assign n_srt = srt_w[i];
		end else begin : g_mid
			assign n_raw = raw_w[i+1];
			assign n_srt = srt_w[i+1];
		end
		car_cell #(.IDX(i), .SB(SB), .CW(CW)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.wr_idx   (fill_q),
			.din      (din),
			.n_incl   (n_q),
			.prev_srt (p_srt),
			.prev_lt  (p_lt),
			.next_raw (n_raw),
			.next_srt (n_srt),
			.raw      (raw_w[i]),
			.srt      (srt_w[i]),
			.lt       (lt_w[i])
		);
	end

	car_div #(.NW(SW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// ---------------- output register ----------------
	assign diff = 34'(raw_w[0]) - 34'(ref_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_free) begin
			ov_q <= emit_go;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			ochan_q <= car_pkg::CHAN_W'(emit_q);
			oval_q  <= diff[car_pkg::VALUE_W-1:0];
			olast_q <= (emit_q == fill_q - CW'(1));
			ostat_q <= status_q;
		end
	end

	assign results.valid   = ov_q;
	assign results.channel = ochan_q;
	assign results.value   = oval_q;
	assign results.last    = olast_q;
	assign results.status  = ostat_q;

	// ---------------- assertions ----------------
	a_incl_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= fill_q)
		else $error("included count exceeds stored count");

	a_close_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		acc && samples.last_in_row |=> st_q == car_pkg::S_PREP)
		else $error("closing beat did not start reference");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == car_pkg::S_EMIT |-> fill_q != '0)
		else $error("emitting an empty row");

	a_med_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == car_pkg::S_MED |-> cnt_q < n_q)
		else $error("median shift count out of range");

	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> st_q == car_pkg::S_LOAD && fill_q == '0)
		else $error("row not cleared after last beat");

endmodule

@@ sim/car_checker.sv @@
// ----------------------------------------------------------------------------
// car_checker: result checker of the common average reference
// Watches the sample and result channels and the register port, rebuilds
// each row, forms the mean or median reference and compares every result
// beat with the oldest expected one.
// ----------------------------------------------------------------------------
module car_checker
	import car_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	car_in_if.monitor            samples,
	car_out_if.monitor           results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending,
	output logic                 accepted
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CH = CHANNELS_DEF;

	typedef struct packed {
		logic [CHAN_W-1:0]          channel;
		logic signed [VALUE_W-1:0]  value;
		logic                       last;
		logic [STATUS_W-1:0]        status;
	} ref_beat_t;

	logic              median_mode;
	logic [MASK_W-1:0] excl_mask;
	logic signed [SAMPLE_W-1:0] row [CH];
	int                fill;
	logic              dropped;
	ref_beat_t         expected_q[$];

	assign pending  = expected_q.size();
	assign accepted = (samples.valid && samples.ready) || (results.valid && results.ready);

	function automatic longint floor_half(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q -= 1;
		return q;
	endfunction

	// form the reference of the closed row and queue one beat per channel
	task automatic close_row();
		longint kept[$];
		longint sum, refv, t;
		int n;
		logic [STATUS_W-1:0] st;
		ref_beat_t b;
		sum = 0;
		refv = 0;
		for (int c = 0; c < fill; c++)
			if (!(c < 32 && excl_mask[c]))
				kept.insert(kept.size(), row[c]);
		n = kept.size();
		if (n > 0) begin
			if (median_mode) begin
				for (int i = 1; i < n; i++)
					for (int j = i; j > 0 && kept[j-1] > kept[j]; j--) begin
						t = kept[j]; kept[j] = kept[j-1]; kept[j-1] = t;
					end
				if (n % 2)
					refv = kept[n/2];
				else
					refv = floor_half(kept[n/2-1] + kept[n/2], 2);
			end else begin
				foreach (kept[i])
					sum += kept[i];
				refv = floor_half(sum, n);
			end
		end
		st = dropped ? ST_OVERFLOW : (n == 0 ? ST_NO_REF : ST_OK);
		for (int c = 0; c < fill; c++) begin
			b.channel = c[CHAN_W-1:0];
			b.value   = VALUE_W'(longint'(row[c]) - refv);
			b.last    = (c + 1 == fill);
			b.status  = st;
			expected_q.insert(expected_q.size(), b);
		end
		fill = 0;
		dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ref_beat_t e;
		if (!arst_n) begin
			median_mode <= 0;
			excl_mask   <= '0;
			fill = 0;
			dropped = 0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_USE_MEDIAN)
					median_mode <= cfg_data[0];
				else if (cfg_idx == REG_EXCLUDE_MASK)
					excl_mask <= cfg_data[MASK_W-1:0];
			end
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat ch=%0d value=%0d", $time,
						results.channel, results.value);
				end else begin
					e = expected_q.pop_front();
					if (results.channel !== e.channel || results.value !== e.value ||
							results.last !== e.last || results.status !== e.status) begin
						errors++;
						$display("%0t: expected ch=%0d value=%0d last=%0b status=%0d",
							$time, e.channel, e.value, e.last, e.status);
						$display("%0t: actual   ch=%0d value=%0d last=%0b status=%0d",
							$time, results.channel, results.value, results.last,
							results.status);
					end
				end
			end
			if (samples.valid && samples.ready) begin
				if (fill < CH) begin
					row[fill] = samples.sample;
					fill++;
				end else
					dropped = 1;
				if (samples.last_in_row)
					close_row();
			end
		end
	end
endmodule

@@ sim/tb_common_average_reference.sv @@
// ----------------------------------------------------------------------------
// tb_common_average_reference: testbench of the common average reference
// Drives rows of channel samples under mean and median modes and a range of
// exclusion masks, with random gaps on both channels; the checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_common_average_reference;
	import car_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int errors, pending;
	logic accepted;
	int sent = 0;          // random-phase samples sent so far
	int idle_cycles = 0;

	car_in_if  samples_if();
	car_out_if results_if();

	common_average_reference i_dut (
		.clk(clk), .arst_n(arst_n),
		.samples(samples_if.sink), .results(results_if.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	car_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.samples(samples_if.monitor), .results(results_if.monitor),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .accepted(accepted)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		samples_if.valid = 0;
		samples_if.sample = '0;
		samples_if.last_in_row = 0;
		results_if.ready = 0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		int g;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 150) begin
				held = 1;
				results_if.ready <= 0;
				repeat (300) @(posedge clk);
			end
			g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			results_if.ready <= (g == 0);
			if (g > 0)
				repeat (g - 1) @(posedge clk);
		end
	end

	// watchdog: cycles without any beat or register write
	always @(posedge clk) begin
		if (accepted || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL common_average_reference");
			$finish;
		end
	end

	// send one beat, hold valid until accepted, optional gap afterward
	task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic lst,
			input logic gaps);
		int g;
		samples_if.valid <= 1;
		samples_if.sample <= s;
		samples_if.last_in_row <= lst;
		do @(posedge clk); while (!samples_if.ready);
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			samples_if.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drop_valid();
		samples_if.valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SAMPLE_W'($urandom_range(0, 7)) - 16'sd4;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_row(input int n, input logic gaps);
		for (int i = 0; i < n; i++)
			send_beat(rand_sample(), i == n - 1, gaps);
	endtask

	// wait until every expected beat is out, then let the block settle
	task automatic drain();
		drop_valid();
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_mask();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 32'h0000_0001 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int len;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, both modes, all-excluded, overflow, single channel
		send_beat(16'sh7fff, 0, 0);
		send_beat(16'sh8000, 0, 0);
		send_beat(16'sh7fff, 0, 0);
		send_beat(-16'sd3, 1, 0);
		send_beat(16'sh8000, 1, 0);
		drain();
		write_reg(REG_USE_MEDIAN, 32'd1);
		send_beat(16'sd5, 0, 0);
		send_beat(-16'sd2, 0, 0);
		send_beat(16'sh8000, 0, 0);
		send_beat(-16'sd7, 1, 0);
		send_beat(16'sd9, 0, 0);
		send_beat(16'sh7fff, 0, 0);
		send_beat(-16'sd1, 1, 0);
		drain();
		write_reg(REG_EXCLUDE_MASK, 32'hffff_ffff);
		send_row(4, 0);
		drain();
		write_reg(REG_EXCLUDE_MASK, 32'h0000_0005);
		write_reg(REG_USE_MEDIAN, 32'hffff_fffe);    // bit 0 clear: mean
		send_row(34, 0);                              // overflow, closing beat dropped
		drain();

		// random: rows of random length, settings changed between phases
		while (sent < 300) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				write_reg(REG_USE_MEDIAN, $urandom);
				write_reg(REG_EXCLUDE_MASK, rand_mask());
			end
			case ($urandom_range(0, 9))
				0: len = 32;
				1: len = $urandom_range(33, 36);
				default: len = $urandom_range(1, 8);
			endcase
			send_row(len, $urandom_range(0, 2) != 0);
			sent += len;
		end
		drain();
		while (idle_cycles > 0 && pending != 0) @(posedge clk);

		if (errors == 0)
			$display("PASS common_average_reference");
		else
			$display("FAIL common_average_reference");
		$finish;
	end
endmodule
